// ===== hdl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types, register indexes and digit helpers for the nixie frame
// sequencer.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int TUBES = 6;

    localparam logic [2:0] CFG_DISPLAY_ON  = 3'd0;
    localparam logic [2:0] CFG_BLINK_DOTS  = 3'd1;
    localparam logic [2:0] CFG_HOURS_24    = 3'd2;
    localparam logic [2:0] CFG_CLEAN_HOUR  = 3'd3;
    localparam logic [2:0] CFG_CLEAN_TICKS = 3'd4;

    localparam logic [4:0]  RST_CLEAN_HOUR  = 5'd4;
    localparam logic [11:0] RST_CLEAN_TICKS = 12'd3000;
    localparam logic [4:0]  HOUR_HALF       = 5'd12;
    localparam logic [3:0]  LAST_DIGIT      = 4'd9;

    // lowest frame bit of each tube's cathode group: seconds ones first
    localparam logic [5:0] TUBE_LSB [TUBES] = '{6'd50, 6'd40, 6'd30, 6'd20, 6'd10, 6'd0};

    typedef struct packed {
        logic        display_on;
        logic        blink_dots;
        logic        hours_24;
        logic [4:0]  clean_hour;
        logic [11:0] clean_ticks;
    } nts_cfg_t;

    // digit[0] seconds ones ... digit[5] hours tens
    typedef struct packed {
        logic [TUBES-1:0][3:0] digit;
        logic                  odd;
        logic                  clean;
    } nts_item_t;

    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = {8'd0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] v);
        logic [6:0] t;
        t = {3'd0, div10(v)} * 7'd10;
        return 4'(v - t);
    endfunction

endpackage

// ===== hdl/nts_front.sv =====
// ----------------------------------------------------------------------------
// nts_front
// Accepts time ticks, tracks the last time and the cleaning run, and queues
// the digits of each frame to be shown.
// ----------------------------------------------------------------------------
module nts_front import nts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  nts_cfg_t    cfg,
    input  logic        tick_valid,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic        q_full,
    output logic        tick_ready,
    output logic        push,
    output nts_item_t   push_item
);

    logic        have_last_reg, have_last_next;
    logic [4:0]  last_hour_reg, last_hour_next;
    logic [5:0]  last_minute_reg, last_minute_next;
    logic [5:0]  last_second_reg, last_second_next;
    logic        cleaning_reg, cleaning_next;
    logic [3:0]  clean_digit_reg, clean_digit_next;
    logic [11:0] clean_count_reg, clean_count_next;

    logic        take;
    logic        changed;
    logic [4:0]  hh;
    logic [11:0] count_inc;

    assign tick_ready = ~q_full;
    assign take       = tick_valid & tick_ready;
    assign changed    = ~have_last_reg || hour != last_hour_reg
                        || minute != last_minute_reg || second != last_second_reg;
    assign count_inc  = clean_count_reg + 12'd1;

    always_comb begin
        hh = hour;
        if (~cfg.hours_24 && hour >= HOUR_HALF) begin
            hh = hour - HOUR_HALF;
            if (hh == 5'd0) begin
                hh = HOUR_HALF;
            end
        end
    end

    always_comb begin
        have_last_next   = have_last_reg;
        last_hour_next   = last_hour_reg;
        last_minute_next = last_minute_reg;
        last_second_next = last_second_reg;
        cleaning_next    = cleaning_reg;
        clean_digit_next = clean_digit_reg;
        clean_count_next = clean_count_reg;
        push             = 1'b0;
        push_item        = '0;
        if (take) begin
            if (cleaning_reg) begin
                push = 1'b1;
                for (int i = 0; i < TUBES; i++) begin
                    push_item.digit[i] = clean_digit_reg;
                end
                push_item.odd    = clean_digit_reg[0];
                push_item.clean  = 1'b1;
                clean_digit_next = (clean_digit_reg == LAST_DIGIT) ? 4'd0
                                                                   : clean_digit_reg + 4'd1;
                clean_count_next = count_inc;
                if (count_inc >= cfg.clean_ticks) begin
                    cleaning_next    = 1'b0;
                    clean_count_next = 12'd0;
                end
            end else begin
                if (changed) begin
                    push               = 1'b1;
                    have_last_next     = 1'b1;
                    last_hour_next     = hour;
                    last_minute_next   = minute;
                    last_second_next   = second;
                    push_item.digit[0] = mod10({1'b0, second});
                    push_item.digit[1] = div10({1'b0, second});
                    push_item.digit[2] = mod10({1'b0, minute});
                    push_item.digit[3] = div10({1'b0, minute});
                    push_item.digit[4] = mod10({2'b0, hh});
                    push_item.digit[5] = div10({2'b0, hh});
                    push_item.odd      = second[0];
                    push_item.clean    = 1'b0;
                end
                if (have_last_next && last_hour_next == cfg.clean_hour
                    && last_minute_next == 6'd0 && last_second_next == 6'd0) begin
                    cleaning_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (~aresetn) begin
            have_last_reg   <= 1'b0;
            last_hour_reg   <= '0;
            last_minute_reg <= '0;
            last_second_reg <= '0;
            cleaning_reg    <= 1'b0;
            clean_digit_reg <= '0;
            clean_count_reg <= '0;
        end else begin
            have_last_reg   <= have_last_next;
            last_hour_reg   <= last_hour_next;
            last_minute_reg <= last_minute_next;
            last_second_reg <= last_second_next;
            cleaning_reg    <= cleaning_next;
            clean_digit_reg <= clean_digit_next;
            clean_count_reg <= clean_count_next;
        end
    end

endmodule

// ===== hdl/nts_queue.sv =====
// ----------------------------------------------------------------------------
// nts_queue
// Two-entry queue between the tick front end and the frame builder.
// ----------------------------------------------------------------------------
module nts_queue import nts_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  nts_item_t push_item,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output nts_item_t head
);

    nts_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (~aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/nts_back.sv =====
// ----------------------------------------------------------------------------
// nts_back
// Builds the active-low frame from queued digits and holds it in the output
// register until transfer.
// ----------------------------------------------------------------------------
module nts_back import nts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  nts_cfg_t    cfg,
    input  logic        q_not_empty,
    input  nts_item_t   q_head,
    output logic        pop,
    output logic        out_valid,
    output logic [63:0] out_frame,
    output logic        out_clean,
    input  logic        out_ready
);

    logic        valid_reg, valid_next;
    logic [63:0] frame_reg;
    logic        clean_reg;
    logic [63:0] frame_build;
    logic [5:0]  pos [TUBES];

    assign pop        = q_not_empty & (~valid_reg | out_ready);
    assign valid_next = pop | (valid_reg & ~out_ready);
    assign out_valid  = valid_reg;
    assign out_frame  = frame_reg;
    assign out_clean  = clean_reg;

    always_comb begin
        frame_build = '1;
        for (int i = 0; i < TUBES; i++) begin
            pos[i] = TUBE_LSB[i] + {2'b0, q_head.digit[i]};
        end
        if (cfg.display_on) begin
            if (q_head.odd && cfg.blink_dots) begin
                frame_build[63:60] = 4'b0000;
            end
            for (int i = 0; i < TUBES; i++) begin
                frame_build[pos[i]] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            frame_reg <= frame_build;
            clean_reg <= q_head.clean;
        end
    end

    always_ff @(posedge aclk) begin
        if (~aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hdl/nixie_time_frame_sequencer.sv =====
// Path: a tick that yields a frame is written into the two-entry queue, then into the
// output register, and from there shows on m_axis. Throughput: one tick per cycle while
// the queue is not full; the two-entry queue and the output register let input and output stall independently.
// Reset (aresetn low, synchronous) clears time tracking, the cleaning run and the
// queue, and returns the registers to their defaults.
// ----------------------------------------------------------------------------
// nixie_time_frame_sequencer
// Turns time ticks into six-tube active-low frames, with cathode cleaning runs.
// ----------------------------------------------------------------------------
module nixie_time_frame_sequencer import nts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // hour[4:0], minute[10:5], second[16:11]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // frame[63:0]
    output logic [0:0]  m_axis_tuser    // cleaning_now[0]
);

    nts_cfg_t  cfg_reg, cfg_next;
    logic      push, pop, q_full, q_not_empty;
    nts_item_t push_item, q_head;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DISPLAY_ON:  cfg_next.display_on  = cfg_data[0];
                CFG_BLINK_DOTS:  cfg_next.blink_dots  = cfg_data[0];
                CFG_HOURS_24:    cfg_next.hours_24    = cfg_data[0];
                CFG_CLEAN_HOUR:  cfg_next.clean_hour  = cfg_data[4:0];
                CFG_CLEAN_TICKS: cfg_next.clean_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (~aresetn) begin
            cfg_reg.display_on  <= 1'b1;
            cfg_reg.blink_dots  <= 1'b1;
            cfg_reg.hours_24    <= 1'b1;
            cfg_reg.clean_hour  <= RST_CLEAN_HOUR;
            cfg_reg.clean_ticks <= RST_CLEAN_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    nts_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .tick_valid (s_axis_tvalid),
        .hour       (s_axis_tdata[4:0]),
        .minute     (s_axis_tdata[10:5]),
        .second     (s_axis_tdata[16:11]),
        .q_full     (q_full),
        .tick_ready (s_axis_tready),
        .push       (push),
        .push_item  (push_item)
    );

    nts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    nts_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_frame   (m_axis_tdata),
        .out_clean   (m_axis_tuser[0]),
        .out_ready   (m_axis_tready)
    );

endmodule

// ===== bench/nixie_time_frame_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nixie_time_frame_sequencer_test
// Self-checking bench for the nixie frame sequencer. Time ticks go in on
// s_axis with random gaps, and frames come out on m_axis with random stalls.
// An in-bench tracker of time, mode and cleaning state predicts every frame,
// and each frame is compared with the oldest pending prediction. Directed
// tests cover the first tick, the 12-hour fold, blanking, the dots and
// cleaning runs. Random phases follow with a ticking clock, noise and jumps
// to just before the cleaning hour.
// ----------------------------------------------------------------------------
module nixie_time_frame_sequencer_test;
    import nts_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [63:0] frame;
        logic        cleaning_now;
    } frame_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_DISPLAY_ON;
    logic [11:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // hour[4:0], minute[10:5], second[16:11]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // frame[63:0]
    logic [0:0]  m_axis_tuser;          // cleaning_now[0]

    // tracked registers
    logic        disp_on = 1'b1;
    logic        blink_on = 1'b1;
    logic        h24_on = 1'b1;
    logic [4:0]  clean_at = RST_CLEAN_HOUR;
    logic [11:0] clean_len = RST_CLEAN_TICKS;

    // tracked time and cleaning state
    logic        have_time = 1'b0;
    logic [4:0]  seen_h = '0;
    logic [5:0]  seen_m = '0;
    logic [5:0]  seen_s = '0;
    logic        in_clean = 1'b0;
    int          clean_digit = 0;
    int          clean_done = 0;

    frame_t      frames_due[$];
    frame_t      oldest_due;
    int          mismatches = 0;
    int          cycles = 0;
    int          stall_left = 0;
    logic        steady = 1'b0;

    nixie_time_frame_sequencer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("nixie_time_frame_sequencer regression: fail");
            $finish;
        end
    end

    function automatic int idle_draw();
        if (steady || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [63:0] tube_frame(input int h, input int m, input int s);
        logic [63:0] w;
        int          dg[6];
        int          i;
        int          pos;
        w = '1;
        if (!disp_on) begin
            return w;
        end
        if ((s % 2) == 1 && blink_on) begin
            w[63:60] = 4'b0000;
        end
        dg[0] = s % 10; dg[1] = s / 10;
        dg[2] = m % 10; dg[3] = m / 10;
        dg[4] = h % 10; dg[5] = h / 10;
        for (i = 0; i < 6; i++) begin
            if (dg[i] > 9) begin
                dg[i] = 9;
            end
            pos = 4 + 10 * i + 9 - dg[i];
            w[63 - pos] = 1'b0;
        end
        return w;
    endfunction

    function automatic void predict_tick(input logic [4:0] h, input logic [5:0] m,
                                         input logic [5:0] s);
        int     hh;
        int     v;
        frame_t f;
        if (!in_clean) begin
            if (!have_time || h != seen_h || m != seen_m || s != seen_s) begin
                have_time = 1'b1;
                seen_h = h; seen_m = m; seen_s = s;
                hh = h;
                if (!h24_on && hh >= 12) begin
                    hh -= 12;
                    if (hh == 0) begin
                        hh = 12;
                    end
                end
                f.frame = tube_frame(hh, m, s);
                f.cleaning_now = 1'b0;
                frames_due.push_back(f);
            end
            if (have_time && seen_h == clean_at && seen_m == 0 && seen_s == 0) begin
                in_clean = 1'b1;
            end
        end else begin
            v = clean_digit * 11;
            f.frame = tube_frame(v, v, v);
            f.cleaning_now = 1'b1;
            frames_due.push_back(f);
            clean_digit = (clean_digit + 1) % 10;
            clean_done = (clean_done + 1) % 4096;
            if (clean_done >= clean_len) begin
                in_clean = 1'b0;
                clean_done = 0;
            end
        end
    endfunction

    // result side: random stalls, compare each frame with the oldest prediction
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            stall_left = idle_draw();
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_axis_tready <= (stall_left == 0);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (frames_due.size() == 0) begin
                $error("frame 0x%016h arrived with no tick pending", m_axis_tdata);
                mismatches++;
            end else begin
                oldest_due = frames_due.pop_front();
                if (m_axis_tdata !== oldest_due.frame) begin
                    $error("frame: expected 0x%016h, got 0x%016h",
                           oldest_due.frame, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== oldest_due.cleaning_now) begin
                    $error("cleaning_now: expected %0b, got %0b",
                           oldest_due.cleaning_now, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_tick(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, s, m, h};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_tick(h, m, s);
    endtask

    // hold off input until every pending frame has arrived, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (frames_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_DISPLAY_ON:  disp_on = val[0];
            CFG_BLINK_DOTS:  blink_on = val[0];
            CFG_HOURS_24:    h24_on = val[0];
            CFG_CLEAN_HOUR:  clean_at = val[4:0];
            CFG_CLEAN_TICKS: clean_len = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_first_tick();
        send_tick(5'd0, 6'd0, 6'd0);
        send_tick(5'd0, 6'd0, 6'd0);
        send_tick(5'd23, 6'd59, 6'd59);
        send_tick(5'd23, 6'd59, 6'd60);
        send_tick(5'd31, 6'd63, 6'd63);
        send_tick(5'd0, 6'd0, 6'd1);
        settle();
    endtask

    task automatic test_hour_fold();
        cfg_write(CFG_HOURS_24, 12'd0);
        send_tick(5'd12, 6'd0, 6'd1);
        send_tick(5'd13, 6'd30, 6'd2);
        send_tick(5'd23, 6'd59, 6'd3);
        send_tick(5'd0, 6'd15, 6'd4);
        send_tick(5'd11, 6'd45, 6'd5);
        send_tick(5'd24, 6'd1, 6'd6);
        send_tick(5'd31, 6'd2, 6'd7);
        settle();
        cfg_write(CFG_HOURS_24, 12'd1);
    endtask

    task automatic test_blank_and_dots();
        cfg_write(CFG_BLINK_DOTS, 12'd0);
        send_tick(5'd7, 6'd7, 6'd7);
        send_tick(5'd7, 6'd7, 6'd8);
        settle();
        cfg_write(CFG_DISPLAY_ON, 12'd0);
        send_tick(5'd8, 6'd8, 6'd9);
        send_tick(5'd8, 6'd8, 6'd10);
        settle();
        cfg_write(CFG_DISPLAY_ON, 12'd1);
        cfg_write(CFG_BLINK_DOTS, 12'd1);
    endtask

    task automatic test_cleaning();
        cfg_write(CFG_CLEAN_HOUR, 12'd23);
        cfg_write(CFG_CLEAN_TICKS, 12'd0);
        send_tick(5'd22, 6'd59, 6'd59);
        send_tick(5'd23, 6'd0, 6'd0);
        send_tick(5'd5, 6'd5, 6'd5);
        // unchanged time at the cleaning hour restarts a run with no frame
        send_tick(5'd23, 6'd0, 6'd0);
        send_tick(5'd1, 6'd2, 6'd3);
        send_tick(5'd23, 6'd0, 6'd1);
        settle();
        cfg_write(CFG_CLEAN_HOUR, 12'd0);
        cfg_write(CFG_CLEAN_TICKS, 12'd4095);
        send_tick(5'd0, 6'd0, 6'd0);
        repeat (5) send_tick(5'd9, 6'd9, 6'd9);
        settle();
        // shorten the run below the count already reached
        cfg_write(CFG_CLEAN_TICKS, 12'd1);
        send_tick(5'd9, 6'd9, 6'd9);
        send_tick(5'd0, 6'd0, 6'd0);
        send_tick(5'd3, 6'd3, 6'd3);
        send_tick(5'd0, 6'd0, 6'd2);
        settle();
    endtask

    task automatic test_random_time(input int phases, input int per_phase);
        int          p;
        int          r;
        logic [4:0]  h;
        logic [5:0]  m;
        logic [5:0]  s;
        for (p = 0; p < phases; p++) begin
            settle();
            cfg_write(CFG_DISPLAY_ON, ($urandom_range(0, 3) != 0) ? 12'd1 : 12'd0);
            cfg_write(CFG_BLINK_DOTS, 12'($urandom_range(0, 1)));
            cfg_write(CFG_HOURS_24, 12'($urandom_range(0, 1)));
            cfg_write(CFG_CLEAN_HOUR, 12'($urandom_range(0, 23)));
            cfg_write(CFG_CLEAN_TICKS, ($urandom_range(0, 7) == 0) ?
                      12'($urandom_range(0, 4095)) % 12'd97 : 12'($urandom_range(1, 24)));
            steady = ($urandom_range(0, 3) == 0);
            h = 5'((clean_at + 23) % 24);
            m = 6'd59;
            s = 6'($urandom_range(40, 59));
            repeat (per_phase) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    // repeat the same time, as between polls
                end else if (r < 92) begin
                    if (s == 6'd59 && $urandom_range(0, 19) == 0) begin
                        s = 6'd60;
                    end else if (s >= 6'd59) begin
                        s = 6'd0;
                        m = (m >= 6'd59) ? 6'd0 : m + 6'd1;
                        if (m == 6'd0) begin
                            h = (h >= 5'd23) ? 5'd0 : h + 5'd1;
                        end
                    end else begin
                        s = s + 6'd1;
                    end
                end else if (r < 96) begin
                    h = 5'($urandom);
                    m = 6'($urandom);
                    s = 6'($urandom);
                end else begin
                    h = 5'((clean_at + 23) % 24);
                    m = 6'd59;
                    s = 6'($urandom_range(50, 59));
                end
                send_tick(h, m, s);
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_tick();
        test_hour_fold();
        test_blank_and_dots();
        test_cleaning();
        test_random_time(8, 125);
        settle();
        if (mismatches == 0) begin
            $display("nixie_time_frame_sequencer regression: pass");
        end else begin
            $display("nixie_time_frame_sequencer regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/nts_pkg.sv
hdl/nts_front.sv
hdl/nts_queue.sv
hdl/nts_back.sv
hdl/nixie_time_frame_sequencer.sv
bench/nixie_time_frame_sequencer_test.sv
